// ===== rtl/qabm_pkg.sv =====
// shared types and constants for the quote-aware bracket matcher
package qabm_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_MAX_LINE    = 1024;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int CHAR_W = 8;
  localparam int QPOS_W = 10;
  localparam int OUT_W  = 16;

  typedef enum logic [1:0] {
    KIND_PAREN,
    KIND_SQUARE,
    KIND_CURLY
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } opcode_t;

  // one classified character as handed from front to back
  typedef struct packed {
    opcode_t code;
    kind_t   kind;
    logic    line_ovf;
    logic    last;
  } op_t;

endpackage

// ===== rtl/qabm_front.sv =====
// front end: takes characters, tracks position and quoting, classifies brackets
module qabm_front import qabm_pkg::*; #(
  parameter int MAX_LINE = DEF_MAX_LINE,
  localparam int POS_W   = $clog2(MAX_LINE),
  localparam int LINE_W  = $clog2(MAX_LINE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,
  input  logic              in_tlast,
  output logic              q_valid,
  input  logic              q_ready,
  output op_t               q_op,
  output logic [POS_W-1:0]  q_pos
);

  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_LSQUARE = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_LCURLY  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_RSQUARE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_RCURLY  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;

  logic [LINE_W-1:0] char_idx_r, char_idx_nxt;
  logic              quote_r, quote_nxt;
  logic              in_range;
  logic              accept;

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;
  assign accept    = in_tvalid && in_tready;
  assign in_range  = char_idx_r < LINE_W'(MAX_LINE);
  assign q_pos     = char_idx_r[POS_W-1:0];

  always_comb begin
    q_op.code     = OP_NONE;
    q_op.kind     = KIND_PAREN;
    q_op.line_ovf = !in_range;
    q_op.last     = in_tlast;
    if (in_range && !quote_r) begin
      case (in_tdata)
        CH_LPAREN:  begin q_op.code = OP_PUSH; q_op.kind = KIND_PAREN;  end
        CH_LSQUARE: begin q_op.code = OP_PUSH; q_op.kind = KIND_SQUARE; end
        CH_LCURLY:  begin q_op.code = OP_PUSH; q_op.kind = KIND_CURLY;  end
        CH_RPAREN:  begin q_op.code = OP_POP;  q_op.kind = KIND_PAREN;  end
        CH_RSQUARE: begin q_op.code = OP_POP;  q_op.kind = KIND_SQUARE; end
        CH_RCURLY:  begin q_op.code = OP_POP;  q_op.kind = KIND_CURLY;  end
        default: ;
      endcase
    end
  end

  always_comb begin
    char_idx_nxt = char_idx_r;
    quote_nxt    = quote_r;
    if (accept) begin
      if (in_tlast) begin
        char_idx_nxt = '0;
        quote_nxt    = 1'b0;
      end else if (in_range) begin
        char_idx_nxt = char_idx_r + LINE_W'(1);
        if (in_tdata == CH_QUOTE) begin
          quote_nxt = !quote_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_idx_r <= '0;
      quote_r    <= 1'b0;
    end else begin
      char_idx_r <= char_idx_nxt;
      quote_r    <= quote_nxt;
    end
  end

endmodule

// ===== rtl/qabm_fifo.sv =====
// small register queue between front and back
module qabm_fifo import qabm_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_ready  = cnt_r != CNT_W'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count past depth");

endmodule

// ===== rtl/qabm_back.sv =====
// back end: bracket stack, partner search and result register
module qabm_back import qabm_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_LINE    = DEF_MAX_LINE,
  localparam int POS_W      = $clog2(MAX_LINE)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [QPOS_W-1:0] cfg_wdata,
  input  logic              q_valid,
  output logic              q_ready,
  input  op_t               q_op,
  input  logic [POS_W-1:0]  q_pos,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata
);

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = (POS_W > QPOS_W) ? POS_W : QPOS_W;

  // top of stack lives in registers, entries below it in the memory
  kind_t            mem_kind [STACK_DEPTH];
  logic [POS_W-1:0] mem_pos  [STACK_DEPTH];

  logic [CNT_W-1:0]  count_r, count_nxt;
  kind_t             top_kind_r, top_kind_nxt;
  logic [POS_W-1:0]  top_pos_r, top_pos_nxt;
  kind_t             below_kind_r;
  logic [POS_W-1:0]  below_pos_r;
  logic              hit_r, hit_nxt;
  logic [POS_W-1:0]  hit_pos_r, hit_pos_nxt;
  logic              ovf_r, ovf_nxt;
  logic [QPOS_W-1:0] qpos_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic              hit_w, ovf_w;
  logic [POS_W-1:0]  hit_pos_w;
  logic [CNT_W-1:0]  count_w;
  logic [CMP_W-1:0]  qpos_ext, hit_pos_ext;
  logic [QPOS_W-1:0] match_w;
  logic [CNT_W-1:0]  cnt_m1, cnt_rd;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic              wr_en;
  logic              out_free, go;

  assign out_free = !out_valid_r || out_tready;
  assign q_ready  = !q_op.last || out_free;
  assign go       = q_valid && q_ready;
  assign qpos_ext = CMP_W'(qpos_r);
  assign cnt_m1   = count_r - CNT_W'(1);
  assign wr_addr  = cnt_m1[IDX_W-1:0];

  always_comb begin
    count_w      = count_r;
    top_kind_nxt = top_kind_r;
    top_pos_nxt  = top_pos_r;
    hit_w        = hit_r;
    hit_pos_w    = hit_pos_r;
    ovf_w        = ovf_r;
    wr_en        = 1'b0;
    if (go) begin
      ovf_w = ovf_r | q_op.line_ovf;
      case (q_op.code)
        OP_PUSH: begin
          if (count_r < CNT_W'(STACK_DEPTH)) begin
            wr_en        = count_r != '0;
            top_kind_nxt = q_op.kind;
            top_pos_nxt  = q_pos;
            count_w      = count_r + CNT_W'(1);
          end else begin
            ovf_w = 1'b1;
          end
        end
        OP_POP: begin
          if (count_r != '0 && top_kind_r == q_op.kind) begin
            top_kind_nxt = below_kind_r;
            top_pos_nxt  = below_pos_r;
            count_w      = cnt_m1;
            if (!hit_r) begin
              if (CMP_W'(top_pos_r) == qpos_ext) begin
                hit_w     = 1'b1;
                hit_pos_w = q_pos;
              end else if (CMP_W'(q_pos) == qpos_ext) begin
                hit_w     = 1'b1;
                hit_pos_w = top_pos_r;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // end of line: emit result and drop all line state
  always_comb begin
    hit_pos_ext  = CMP_W'(hit_pos_w);
    match_w      = hit_w ? hit_pos_ext[QPOS_W-1:0] : '0;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    count_nxt    = count_w;
    hit_nxt      = hit_w;
    hit_pos_nxt  = hit_pos_w;
    ovf_nxt      = ovf_w;
    if (go && q_op.last) begin
      out_data_nxt  = OUT_W'({ovf_w, match_w, hit_w});
      out_valid_nxt = 1'b1;
      count_nxt     = '0;
      hit_nxt       = 1'b0;
      hit_pos_nxt   = '0;
      ovf_nxt       = 1'b0;
    end
  end

  // prefetch the entry just below the next top
  assign cnt_rd  = count_w - CNT_W'(2);
  assign rd_addr = cnt_rd[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      hit_r       <= 1'b0;
      hit_pos_r   <= '0;
      ovf_r       <= 1'b0;
      qpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      hit_r       <= hit_nxt;
      hit_pos_r   <= hit_pos_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        qpos_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_kind_r <= top_kind_nxt;
    top_pos_r  <= top_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_kind[wr_addr] <= top_kind_r;
      mem_pos[wr_addr]  <= top_pos_r;
      // on a push the old top becomes the entry below
      below_kind_r      <= top_kind_r;
      below_pos_r       <= top_pos_r;
    end else begin
      below_kind_r      <= mem_kind[rd_addr];
      below_pos_r       <= mem_pos[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count past depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && q_op.last |=> count_r == '0 && !hit_r && !ovf_r && out_valid_r)
    else $error("line state not cleared after last transfer");

  a_mismatch_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    go && !q_op.last && q_op.code == OP_POP && count_r != '0 && top_kind_r != q_op.kind
    |=> count_r == $past(count_r))
    else $error("mismatched closer changed the stack");

endmodule

// ===== rtl/quote_aware_bracket_matcher.sv =====
// top level of the quote-aware bracket matcher
//
// Characters of a line arrive on the in_ stream, one byte per transfer, with
// in_tlast on the final character. Text between double quotes is skipped.
// The cfg_ port sets the position of the bracket whose partner is sought; the
// user must write it only between lines, which the block does not enforce.
// After the last character one result comes out on the out_ stream: found,
// partner position and an overflow flag for a full stack or a line longer
// than MAX_LINE. Throughput is one character per cycle unless the queue is
// full or a line end waits on an untaken result, set by the back end doing
// one stack push or pop per cycle with the top entry held in registers and
// the next entry prefetched from the stack memory. The last character passes
// through the queue and then the result register before the result is valid.
// A queue of QUEUE_DEPTH entries separates the front end from the back end;
// when the receiver stalls, the result holds and the back end stops only at
// the next line end, so characters keep flowing until the queue fills.
// Reset clears the line state, the queue and query position; the stack
// memory needs no clearing.
module quote_aware_bracket_matcher import qabm_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_LINE    = DEF_MAX_LINE,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [QPOS_W-1:0] cfg_wdata,   // query_pos
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,    // char_code
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata    // found, match_pos[9:0], overflow, zero pad
);

  localparam int POS_W = $clog2(MAX_LINE);
  localparam int Q_W   = $bits(op_t) + POS_W;

  op_t              f_op, b_op;
  logic [POS_W-1:0] f_pos, b_pos;
  logic             f_valid, f_ready;
  logic             b_valid, b_ready;
  logic [Q_W-1:0]   f_data, b_data;

  qabm_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_op      (f_op),
    .q_pos     (f_pos)
  );

  assign f_data = {f_pos, f_op};

  qabm_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  assign b_op  = op_t'(b_data[$bits(op_t)-1:0]);
  assign b_pos = b_data[Q_W-1:$bits(op_t)];

  qabm_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_LINE    (MAX_LINE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_op       (b_op),
    .q_pos      (b_pos),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/quote_aware_bracket_matcher_tb.sv =====
// testbench for the quote-aware bracket matcher: directed lines, random lines, result checks
`timescale 1ns / 100ps

module quote_aware_bracket_matcher_tb import qabm_pkg::*; ();

  localparam int STACK_DEPTH  = DEF_STACK_DEPTH;
  localparam int MAX_LINE     = DEF_MAX_LINE;
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_FILL   = 8'h78;

  typedef struct packed {
    logic              found;
    logic [QPOS_W-1:0] pos;
    logic              ovf;
  } line_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [QPOS_W-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata;   // char_code
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // found, match_pos[9:0], overflow, zero pad

  quote_aware_bracket_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // matcher state mirrored for prediction
  kind_t             open_kind_mem [STACK_DEPTH];
  logic [QPOS_W-1:0] open_pos_mem [STACK_DEPTH];
  int                open_depth;
  logic              quoted;
  int                col;
  logic              hit;
  logic [QPOS_W-1:0] hit_at;
  logic              ovf;
  logic [QPOS_W-1:0] query;

  line_result_t expected_matches[$];
  line_result_t want;
  logic [7:0]   line_buf[$];

  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_request = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic clear_line_state();
    open_depth = 0;
    quoted     = 1'b0;
    col        = 0;
    hit        = 1'b0;
    hit_at     = '0;
    ovf        = 1'b0;
  endtask

  // advance the mirror by one accepted character
  task automatic scan_char(input logic [7:0] c, input logic last);
    kind_t        k;
    logic         is_open;
    logic         is_close;
    line_result_t r;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_PAREN;
    if (col < MAX_LINE) begin
      if (c == CH_QUOTE) begin
        quoted = !quoted;
      end else if (!quoted) begin
        case (c)
          CH_LPAREN:  begin is_open = 1'b1;  k = KIND_PAREN;  end
          CH_LSQUARE: begin is_open = 1'b1;  k = KIND_SQUARE; end
          CH_LCURLY:  begin is_open = 1'b1;  k = KIND_CURLY;  end
          CH_RPAREN:  begin is_close = 1'b1; k = KIND_PAREN;  end
          CH_RSQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
          CH_RCURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
          default: ;
        endcase
        if (is_open) begin
          if (open_depth < STACK_DEPTH) begin
            open_kind_mem[open_depth] = k;
            open_pos_mem[open_depth]  = col[QPOS_W-1:0];
            open_depth++;
          end else begin
            ovf = 1'b1;
          end
        end else if (is_close && open_depth > 0 && open_kind_mem[open_depth-1] == k) begin
          open_depth--;
          if (!hit) begin
            if (open_pos_mem[open_depth] == query) begin
              hit    = 1'b1;
              hit_at = col[QPOS_W-1:0];
            end else if (col == query) begin
              hit    = 1'b1;
              hit_at = open_pos_mem[open_depth];
            end
          end
        end
      end
      col++;
    end else begin
      ovf = 1'b1;
    end
    if (last) begin
      r.found = hit;
      r.pos   = hit ? hit_at : '0;
      r.ovf   = ovf;
      expected_matches = {expected_matches, r};
      clear_line_state();
    end
  endtask

  function automatic logic [7:0] bracket_char(kind_t k, logic closer);
    case (k)
      KIND_PAREN:  return closer ? CH_RPAREN : CH_LPAREN;
      KIND_SQUARE: return closer ? CH_RSQUARE : CH_LSQUARE;
      default:     return closer ? CH_RCURLY : CH_LCURLY;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_char(c, last);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      send_char(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf = {line_buf, s[i]};
    send_line();
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // query changes only with the block idle
  task automatic write_query(input int q);
    idle_input();
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= QPOS_W'(q);
    query      = QPOS_W'(q);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly nested brackets with random content, plus stray closers, quotes and raw bytes
  task automatic build_random_line(input int q);
    kind_t open_kinds[$];
    kind_t k;
    int    len;
    int    r;
    line_buf.delete();
    len = ($urandom_range(29) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        k = kind_t'($urandom_range(2));
        open_kinds = {open_kinds, k};
        line_buf = {line_buf, bracket_char(k, 1'b0)};
      end else if (r < 55) begin
        if (open_kinds.size() > 0 && $urandom_range(9) != 0) begin
          k = open_kinds[$];
          open_kinds.delete(open_kinds.size() - 1);
        end else begin
          k = kind_t'($urandom_range(2));
        end
        line_buf = {line_buf, bracket_char(k, 1'b1)};
      end else if (r < 60) begin
        line_buf = {line_buf, CH_QUOTE};
      end else if (r < 66) begin
        line_buf = {line_buf, 8'($urandom_range(255))};
      end else begin
        line_buf = {line_buf, 8'h61 + 8'($urandom_range(25))};
      end
    end
    // put a bracket under the query often enough to get hits
    if (q < len && $urandom_range(1) == 1)
      line_buf[q] = bracket_char(kind_t'($urandom_range(2)), 1'($urandom_range(1)));
  endtask

  task automatic test_basic_pairs();
    write_query(0);
    send_text("()");
    send_text("[]");
    send_text("{}");
    send_text("a");
    send_text("(]");
    send_text("(])");
  endtask

  task automatic test_quotes();
    write_query(0);
    send_text("(\")\")");
    write_query(1);
    send_text("\"(\")");
  endtask

  task automatic test_closer_side();
    write_query(1);
    send_text(")(");
    write_query(3);
    send_text("a(b)");
    write_query(1023);
    send_text("()");
  endtask

  task automatic test_stack_full();
    line_buf.delete();
    repeat (STACK_DEPTH + 1) line_buf = {line_buf, CH_LPAREN};
    repeat (STACK_DEPTH) line_buf = {line_buf, CH_RPAREN};
    write_query(0);
    send_line();
    // the dropped opener can never be matched
    write_query(STACK_DEPTH);
    send_line();
  endtask

  task automatic test_line_bounds();
    line_buf.delete();
    line_buf = {line_buf, CH_LPAREN};
    line_buf = {line_buf, CH_LPAREN};
    repeat (MAX_LINE - 3) line_buf = {line_buf, CH_FILL};
    line_buf = {line_buf, CH_RPAREN};
    // characters past the bound are dropped, so the first opener stays open
    line_buf = {line_buf, CH_RPAREN};
    line_buf = {line_buf, CH_QUOTE};
    line_buf = {line_buf, CH_LPAREN};
    repeat (3) line_buf = {line_buf, CH_FILL};
    write_query(0);
    send_line();
  endtask

  task automatic test_backpressure();
    write_query(1);
    rx_idle_pct  = 0;
    hold_request = 1'b1;
    repeat (30) send_text("(x)");
  endtask

  task automatic test_random_lines(input int tx_pct, input int rx_pct, input int n_chars);
    int sent;
    int q;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_chars) begin
      q = ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(30);
      write_query(q);
      repeat (6) begin
        build_random_line(q);
        sent += line_buf.size();
        send_line();
      end
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_matches.size() == 0) begin
        $error("result transfer with no line pending: %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_matches.pop_front();
        if (out_tdata[0] !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[QPOS_W:1] !== want.pos) begin
          $error("match_pos: expected %0d, actual %0d", want.pos, out_tdata[QPOS_W:1]);
          fail_count++;
        end
        if (out_tdata[QPOS_W+1] !== want.ovf) begin
          $error("overflow: expected %0d, actual %0d", want.ovf, out_tdata[QPOS_W+1]);
          fail_count++;
        end
        if (out_tdata[OUT_W-1:QPOS_W+2] !== '0) begin
          $error("pad: expected 0, actual %h", out_tdata[OUT_W-1:QPOS_W+2]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    query       = '0;
    clear_line_state();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_pairs();
    test_quotes();
    test_closer_side();
    test_stack_full();
    test_line_bounds();
    test_backpressure();
    test_random_lines(31, 78, 120);
    test_random_lines(78, 31, 120);
    test_random_lines(0, 0, 120);

    idle_input();
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qabm_pkg.sv
rtl/qabm_front.sv
rtl/qabm_fifo.sv
rtl/qabm_back.sv
rtl/quote_aware_bracket_matcher.sv
dv/quote_aware_bracket_matcher_tb.sv
